[hdl/jetp_pkg.sv]
// Package for the Julia escape-time pixel block.
// Holds the sequencer state type, register indexes, field widths and the
// saturation helper. Depends on nothing.
`default_nettype none

package jetp_pkg;

  localparam int COL_W   = 10;
  localparam int ROW_W   = 10;
  localparam int CNT_W   = 16;
  localparam int CFG_W   = 31;
  localparam int IDX_W   = 3;
  localparam int CR_W    = 30;
  localparam int SPAN_W  = 31;
  localparam int ZW      = 32;
  localparam int PROD_W  = 2 * ZW;
  localparam int SUM_W   = 66;
  localparam int MAP_W   = COL_W + SPAN_W + 2;
  localparam int MAG_W   = COL_W + SPAN_W;

  localparam logic [IDX_W-1:0] REG_C_REAL   = 3'd0;
  localparam logic [IDX_W-1:0] REG_C_IMAG   = 3'd1;
  localparam logic [IDX_W-1:0] REG_MAX_ITER = 3'd2;
  localparam logic [IDX_W-1:0] REG_X_SPAN   = 3'd3;
  localparam logic [IDX_W-1:0] REG_Y_SPAN   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_MAP,
    ST_ITER_MUL,
    ST_ITER_UPD,
    ST_FINISH
  } state_t;

  function automatic logic signed [ZW-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(33'sh0_7FFF_FFFF);
    lo = -SUM_W'(33'sh0_8000_0000);
    if (v > hi) begin
      return {1'b0, {(ZW-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(ZW-1){1'b0}}};
    end else begin
      return v[ZW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

[hdl/julia_escape_time_pixel_top.sv]
// Julia set escape-time evaluator for one pixel at a time.
// Depends on jetp_pkg and jetp_div.
//
// Usage: a transaction on the s_ channel carries a pixel column (s_tdata[9:0])
// and row (s_tdata[19:10]). The pixel is mapped to a complex start point by
// two dividers by the image size, then z = z*z + c is iterated on one
// shared set of three 32x32 multipliers until |z|^2 reaches 4 or the count
// reaches max_iter. The result leaves on the m_ channel: m_tdata holds the
// count, m_tuser[0] is high if the point escaped.
// The mapping divisions run as four partial products, and each iteration runs
// as a products step and then an update step. The next pixel can be accepted
// in the cycle after a result is loaded into the output register.
// s_tready is high only while no pixel is in work; a finished result waits in
// the output register, so a new pixel is accepted while the receiver stalls,
// and its own result is held back until the register is free.
// The configuration channel is always ready; the user must see that it is
// written only while idle, as the block itself does not enforce this.
// Synchronous reset empties the output register, returns the sequencer to
// idle and restores the default view and constant c.
`default_nettype none

module julia_escape_time_pixel_top #(
  parameter int IMG_WIDTH  = 1024,
  parameter int IMG_HEIGHT = 1024,
  parameter int FRAC_BITS  = 28
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // col[9:0], row[19:10], zero[23:20]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [15:0] m_tdata,   // iter_count[15:0]
  output logic      [0:0]  m_tuser,   // escaped[0]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [30:0] cfg_data
);

  localparam int SUM_W  = jetp_pkg::SUM_W;
  localparam int MAP_W  = jetp_pkg::MAP_W;
  localparam int MAG_W  = jetp_pkg::MAG_W;
  localparam int ZW     = jetp_pkg::ZW;
  localparam int PROD_W = jetp_pkg::PROD_W;
  localparam int CNT_W  = jetp_pkg::CNT_W;
  localparam logic signed [SUM_W-1:0] FOUR = SUM_W'(4) << FRAC_BITS;

  logic signed [jetp_pkg::CR_W-1:0]   c_real;
  logic signed [jetp_pkg::CR_W-1:0]   c_imag;
  logic        [CNT_W-1:0]            max_iter;
  logic signed [jetp_pkg::SPAN_W-1:0] x_half_span;
  logic signed [jetp_pkg::SPAN_W-1:0] y_half_span;

  jetp_pkg::state_t state;
  jetp_pkg::state_t state_next;

  logic signed [MAP_W-1:0]  map_x;
  logic signed [MAP_W-1:0]  map_y;
  logic        [MAG_W-1:0]  mag_x;
  logic        [MAG_W-1:0]  mag_y;
  logic        [MAG_W-1:0]  quo_x;
  logic        [MAG_W-1:0]  quo_y;
  logic                     done_x;
  logic                     done_y;
  logic                     div_start;
  logic signed [MAP_W-1:0]  qx;
  logic signed [MAP_W-1:0]  qy;

  logic signed [ZW-1:0]     zx;
  logic signed [ZW-1:0]     zy;
  logic        [CNT_W-1:0]  count;
  logic signed [PROD_W-1:0] pxx;
  logic signed [PROD_W-1:0] pyy;
  logic signed [PROD_W-1:0] pxy;
  logic signed [SUM_W-1:0]  xx;
  logic signed [SUM_W-1:0]  yy;
  logic signed [SUM_W-1:0]  xy;
  logic                     escape;
  logic                     limit;
  logic                     out_load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_real      <= 30'sd76504351;
      c_imag      <= 30'sd2684355;
      max_iter    <= 16'd300;
      x_half_span <= 31'sd268435456;
      y_half_span <= -31'sd268435456;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        jetp_pkg::REG_C_REAL:   c_real      <= cfg_data[jetp_pkg::CR_W-1:0];
        jetp_pkg::REG_C_IMAG:   c_imag      <= cfg_data[jetp_pkg::CR_W-1:0];
        jetp_pkg::REG_MAX_ITER: max_iter    <= cfg_data[CNT_W-1:0];
        jetp_pkg::REG_X_SPAN:   x_half_span <= cfg_data;
        jetp_pkg::REG_Y_SPAN:   y_half_span <= cfg_data;
        default: ;
      endcase
    end
  end

  assign mag_x = map_x[MAP_W-1] ? MAG_W'(-map_x) : map_x[MAG_W-1:0];
  assign mag_y = map_y[MAP_W-1] ? MAG_W'(-map_y) : map_y[MAG_W-1:0];

  jetp_div #(.DIVISOR(IMG_WIDTH), .N(MAG_W)) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag_x),
    .quotient (quo_x),
    .done     (done_x)
  );

  jetp_div #(.DIVISOR(IMG_HEIGHT), .N(MAG_W)) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag_y),
    .quotient (quo_y),
    .done     (done_y)
  );

  assign qx = map_x[MAP_W-1] ? -MAP_W'($signed({1'b0, quo_x}))
                             : MAP_W'($signed({1'b0, quo_x}));
  assign qy = map_y[MAP_W-1] ? -MAP_W'($signed({1'b0, quo_y}))
                             : MAP_W'($signed({1'b0, quo_y}));

  assign xx     = SUM_W'(pxx >>> FRAC_BITS);
  assign yy     = SUM_W'(pyy >>> FRAC_BITS);
  assign xy     = SUM_W'(pxy >>> FRAC_BITS);
  assign escape = (xx + yy) >= FOUR;
  assign limit  = (count >= max_iter);
  assign out_load = (state == jetp_pkg::ST_FINISH) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jetp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      jetp_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = jetp_pkg::ST_START;
        end
      end
      jetp_pkg::ST_START: begin
        div_start  = 1'b1;
        state_next = jetp_pkg::ST_DIV;
      end
      jetp_pkg::ST_DIV: begin
        if (done_x && done_y) begin
          state_next = jetp_pkg::ST_MAP;
        end
      end
      jetp_pkg::ST_MAP: begin
        state_next = jetp_pkg::ST_ITER_MUL;
      end
      jetp_pkg::ST_ITER_MUL: begin
        state_next = limit ? jetp_pkg::ST_FINISH : jetp_pkg::ST_ITER_UPD;
      end
      jetp_pkg::ST_ITER_UPD: begin
        state_next = escape ? jetp_pkg::ST_FINISH : jetp_pkg::ST_ITER_MUL;
      end
      jetp_pkg::ST_FINISH: begin
        if (out_load) begin
          state_next = jetp_pkg::ST_IDLE;
        end
      end
      default: state_next = jetp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == jetp_pkg::ST_IDLE && s_tvalid) begin
      map_x <= MAP_W'($signed({1'b0, s_tdata[9:0]}) * x_half_span) <<< 1;
      map_y <= MAP_W'($signed({1'b0, s_tdata[19:10]}) * y_half_span) <<< 1;
    end
    if (state == jetp_pkg::ST_MAP) begin
      zx    <= jetp_pkg::sat32(SUM_W'(qx) - SUM_W'(x_half_span));
      zy    <= jetp_pkg::sat32(SUM_W'(qy) - SUM_W'(y_half_span));
      count <= '0;
    end
    if (state == jetp_pkg::ST_ITER_MUL) begin
      pxx <= zx * zx;
      pyy <= zy * zy;
      pxy <= zx * zy;
    end
    if (state == jetp_pkg::ST_ITER_UPD && !escape) begin
      zx    <= jetp_pkg::sat32(xx - yy + SUM_W'(c_real));
      zy    <= jetp_pkg::sat32(xy + xy + SUM_W'(c_imag));
      count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata    <= count;
      m_tuser[0] <= !limit;
    end
  end

endmodule

`default_nettype wire

[hdl/jetp_div.sv]
// Divider of an unsigned dividend by a fixed divisor, by multiplication with a
// rounded-up reciprocal: four partial products, one a cycle, on one small
// multiplier. Depends on nothing.
`default_nettype none

module jetp_div #(
  parameter int DIVISOR = 1024,
  parameter int N       = 41
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [N-1:0] dividend,
  output logic      [N-1:0] quotient,
  output logic              done
);

  // With L = ceil(log2(DIVISOR)) and RECIP = ceil(2^(N+L) / DIVISOR), the
  // product dividend * RECIP shifted right by N + L is the exact quotient
  // for every dividend below 2^N.
  localparam int L   = $clog2(DIVISOR);
  localparam int S   = N + L;
  localparam int MW  = N + 2;
  localparam int HN  = (N + 1) / 2;
  localparam int HM  = (MW + 1) / 2;
  localparam int PW  = HM;
  localparam int AW  = N + MW;
  localparam int SHW = $clog2(AW);
  localparam logic [127:0] POW_S      = 128'd1 << S;
  localparam logic [127:0] RECIP_WIDE =
    (POW_S + 128'(DIVISOR) - 128'd1) / 128'(DIVISOR);
  localparam logic [MW-1:0] RECIP = RECIP_WIDE[MW-1:0];

  logic [N-1:0]    num;
  logic [AW-1:0]   acc;
  logic [1:0]      step;
  logic            busy;
  logic [PW-1:0]   nl;
  logic [PW-1:0]   nh;
  logic [PW-1:0]   ml;
  logic [PW-1:0]   mh;
  logic [PW-1:0]   op_a;
  logic [PW-1:0]   op_b;
  logic [SHW-1:0]  shamt;
  logic [2*PW-1:0] pp;

  assign nl = PW'(num[HN-1:0]);
  assign nh = PW'(num[N-1:HN]);
  assign ml = PW'(RECIP[HM-1:0]);
  assign mh = PW'(RECIP[MW-1:HM]);

  always_comb begin
    case (step)
      2'd0: begin
        op_a  = nl;
        op_b  = ml;
        shamt = '0;
      end
      2'd1: begin
        op_a  = nl;
        op_b  = mh;
        shamt = SHW'(HM);
      end
      2'd2: begin
        op_a  = nh;
        op_b  = ml;
        shamt = SHW'(HN);
      end
      default: begin
        op_a  = nh;
        op_b  = mh;
        shamt = SHW'(HN + HM);
      end
    endcase
  end

  assign pp       = op_a * op_b;
  assign quotient = N'(acc >> S);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && (step == 2'd3);
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      acc <= '0;
    end else if (busy) begin
      acc <= acc + (AW'(pp) << shamt);
    end
  end

endmodule

`default_nettype wire

[hdl/jetp_checker.sv]
// Port-level checks for the Julia escape-time pixel block.
// Bound to julia_escape_time_pixel_top; depends on nothing else.
`default_nettype none

module jetp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic [0:0]  m_tuser
);

  // A pixel in work blocks the input channel.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a pixel was in work");

  // A new result appears only as the sequencer returns to idle.
  a_result_frees_input: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> s_tready)
    else $error("result presented while the sequencer was still busy");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result transaction changed or vanished");

  a_reset_state: assert property (@(posedge clk)
    rst |=> (!m_tvalid && s_tready))
    else $error("block not idle and empty after reset");

endmodule

bind julia_escape_time_pixel_top jetp_checker u_jetp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

[verif/julia_escape_time_pixel_top_tb.sv]
// Self-checking testbench for julia_escape_time_pixel_top: directed table, then random pixels
// across several views, predicted in fixed point and compared result by result.
// Depends on jetp_pkg and the block's RTL only.
`default_nettype none

module julia_escape_time_pixel_top_tb;

  localparam int     FRAC_BITS       = 28;
  localparam longint IMG_W           = 1024;
  localparam longint IMG_H           = 1024;
  localparam longint S32_MAX         = 64'sh0000_0000_7FFF_FFFF;
  localparam longint S32_MIN         = -S32_MAX - 1;
  localparam longint FOUR            = 64'sd4 <<< FRAC_BITS;
  localparam int     WATCHDOG_LIMIT  = 400000;
  localparam int     HOLD_CYCLES     = 2000;
  localparam int     ITEMS_PER_PHASE = 150;
  localparam int     NUM_PHASES      = 6;
  localparam logic [2:0] REG_UNUSED_LO = 3'd5;
  localparam logic [2:0] REG_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [15:0] iter_count;
    logic        escaped;
  } pixel_result_t;

  typedef struct {
    bit            is_reg;
    logic [2:0]    idx;
    logic [30:0]   data;
    logic [9:0]    col;
    logic [9:0]    row;
    bit            known;
    pixel_result_t want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [30:0] cfg_data = '0;

  logic [29:0] cr_q = 30'd76504351;
  logic [29:0] ci_q = 30'd2684355;
  logic [15:0] mi_q = 16'd300;
  logic [30:0] xs_q = 31'd268435456;
  logic [30:0] ys_q = 31'h7000_0000;

  pixel_result_t expected_pixels[$];
  plan_row_t     plan[$];
  int            mismatches = 0;
  int            idle_cycles = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            hold_left = 0;
  bit            hold_req = 1'b0;
  bit            hold_done = 1'b0;

  julia_escape_time_pixel_top u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint clamp_s32(input longint v);
    if (v > S32_MAX) begin
      return S32_MAX;
    end
    if (v < S32_MIN) begin
      return S32_MIN;
    end
    return v;
  endfunction

  function automatic pixel_result_t escape_time(input logic [9:0] col, input logic [9:0] row);
    longint        cr;
    longint        ci;
    longint        xs;
    longint        ys;
    longint        x;
    longint        y;
    longint        xx;
    longint        yy;
    longint        xy;
    longint        nx;
    int unsigned   count;
    pixel_result_t res;
    cr = longint'($signed(cr_q));
    ci = longint'($signed(ci_q));
    xs = longint'($signed(xs_q));
    ys = longint'($signed(ys_q));
    x = clamp_s32((longint'(col) * 2 * xs) / IMG_W - xs);
    y = clamp_s32((longint'(row) * 2 * ys) / IMG_H - ys);
    count = 0;
    while (count < mi_q) begin
      xx = (x * x) >>> FRAC_BITS;
      yy = (y * y) >>> FRAC_BITS;
      if (xx + yy >= FOUR) begin
        break;
      end
      xy = (x * y) >>> FRAC_BITS;
      nx = clamp_s32(xx - yy + cr);
      y  = clamp_s32(xy + xy + ci);
      x  = nx;
      count++;
    end
    res.iter_count = count[15:0];
    res.escaped    = (count < mi_q);
    return res;
  endfunction

  function automatic plan_row_t pix(input logic [9:0] col, input logic [9:0] row);
    plan_row_t r;
    r = '{default: '0};
    r.col = col;
    r.row = row;
    return r;
  endfunction

  function automatic plan_row_t pix_known(input logic [9:0] col, input logic [9:0] row,
                                          input logic [15:0] cnt, input logic esc);
    plan_row_t r;
    r = pix(col, row);
    r.known = 1'b1;
    r.want  = '{iter_count: cnt, escaped: esc};
    return r;
  endfunction

  function automatic plan_row_t reg_wr(input logic [2:0] idx, input logic [30:0] data);
    plan_row_t r;
    r = '{default: '0};
    r.is_reg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch in %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  task automatic send_pixel(input logic [9:0] col, input logic [9:0] row,
                            input bit known, input pixel_result_t want);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, row, col};
    do @(posedge clk); while (!s_tready);
    expected_pixels.push_back(known ? want : escape_time(col, row));
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [30:0] data);
    while (expected_pixels.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      jetp_pkg::REG_C_REAL:   cr_q = data[29:0];
      jetp_pkg::REG_C_IMAG:   ci_q = data[29:0];
      jetp_pkg::REG_MAX_ITER: mi_q = data[15:0];
      jetp_pkg::REG_X_SPAN:   xs_q = data;
      jetp_pkg::REG_Y_SPAN:   ys_q = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    if (hold_left > 0) begin
      hold_left--;
    end
  end

  always @(posedge clk) begin
    pixel_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("result with no pixel pending, iter_count", m_tdata, 0);
      end else begin
        want = expected_pixels.pop_front();
        if (m_tdata !== want.iter_count) begin
          report_mismatch("iter_count", m_tdata, want.iter_count);
        end
        if (m_tuser[0] !== want.escaped) begin
          report_mismatch("escaped", m_tuser[0], want.escaped);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** julia_escape_time_pixel_top: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [9:0] col;
    logic [9:0] row;
    int         v_cr;
    int         v_ci;
    int         v_mi;
    int         v_xs;
    int         v_ys;

    plan.push_back(pix(10'd0, 10'd0));
    plan.push_back(pix(10'd1023, 10'd1023));
    plan.push_back(pix(10'd512, 10'd512));
    plan.push_back(pix(10'd1023, 10'd0));
    plan.push_back(pix(10'd0, 10'd1023));
    plan.push_back(reg_wr(jetp_pkg::REG_C_REAL, 31'd0));
    plan.push_back(reg_wr(jetp_pkg::REG_C_IMAG, 31'd0));
    plan.push_back(reg_wr(jetp_pkg::REG_MAX_ITER, 31'd1));
    plan.push_back(pix_known(10'd512, 10'd512, 16'd1, 1'b0));
    plan.push_back(reg_wr(jetp_pkg::REG_X_SPAN, 31'h3FFF_FFFF));
    plan.push_back(reg_wr(jetp_pkg::REG_Y_SPAN, 31'h4000_0000));
    plan.push_back(pix_known(10'd0, 10'd512, 16'd0, 1'b1));
    plan.push_back(pix_known(10'd512, 10'd0, 16'd0, 1'b1));
    plan.push_back(pix(10'd1023, 10'd1023));
    plan.push_back(reg_wr(jetp_pkg::REG_MAX_ITER, 31'd0));
    plan.push_back(pix_known(10'd512, 10'd0, 16'd0, 1'b0));
    plan.push_back(pix_known(10'd512, 10'd512, 16'd0, 1'b0));
    plan.push_back(reg_wr(REG_UNUSED_LO, 31'h7FFF_FFFF));
    plan.push_back(reg_wr(REG_UNUSED_HI, 31'd0));
    plan.push_back(pix(10'd300, 10'd700));
    plan.push_back(reg_wr(jetp_pkg::REG_MAX_ITER, 31'd65535));
    plan.push_back(pix_known(10'd512, 10'd512, 16'd65535, 1'b0));
    plan.push_back(reg_wr(jetp_pkg::REG_C_REAL, 31'h1FFF_FFFF));
    plan.push_back(reg_wr(jetp_pkg::REG_C_IMAG, 31'h2000_0000));
    plan.push_back(reg_wr(jetp_pkg::REG_MAX_ITER, 31'd300));
    plan.push_back(reg_wr(jetp_pkg::REG_X_SPAN, 31'h4000_0000));
    plan.push_back(reg_wr(jetp_pkg::REG_Y_SPAN, 31'h3FFF_FFFF));
    plan.push_back(pix(10'd0, 10'd0));
    plan.push_back(pix(10'd1023, 10'd1023));
    plan.push_back(pix(10'd511, 10'd513));
    plan.push_back(pix(10'd700, 10'd300));
    plan.push_back(reg_wr(jetp_pkg::REG_C_REAL, 31'h7000_0000));
    plan.push_back(pix(10'd512, 10'd512));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        s_tvalid <= 1'b0;
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_pixel(plan[i].col, plan[i].row, plan[i].known, plan[i].want);
      end
    end
    s_tvalid <= 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          v_cr = 76504351;   v_ci = 2684355;    v_mi = 300;
          v_xs = 268435456;  v_ys = -268435456;
        end
        1: begin
          v_cr = -536870912; v_ci = 536870911;  v_mi = 1;
          v_xs = -1073741824; v_ys = 1073741823;
        end
        2: begin
          v_cr = $urandom_range(0, 429496729) - 214748364;
          v_ci = $urandom_range(0, 429496729) - 214748364;
          v_mi = 40;
          v_xs = $urandom_range(134217728, 536870912);
          v_ys = -int'($urandom_range(134217728, 536870912));
        end
        3: begin
          v_cr = 536870911;  v_ci = -536870912; v_mi = 128;
          v_xs = 536870912;  v_ys = 536870912;
        end
        4: begin
          v_cr = $urandom_range(0, 429496729) - 214748364;
          v_ci = $urandom_range(0, 429496729) - 214748364;
          v_mi = $urandom_range(2, 64);
          v_xs = $urandom_range(134217728, 536870912);
          v_ys = -int'($urandom_range(134217728, 536870912));
        end
        default: begin
          v_cr = -214748365; v_ci = 41875931;   v_mi = 300;
          v_xs = 402653184;  v_ys = -268435456;
        end
      endcase
      write_reg(jetp_pkg::REG_C_REAL, 31'(v_cr));
      write_reg(jetp_pkg::REG_C_IMAG, 31'(v_ci));
      write_reg(jetp_pkg::REG_MAX_ITER, 31'(v_mi));
      write_reg(jetp_pkg::REG_X_SPAN, 31'(v_xs));
      write_reg(jetp_pkg::REG_Y_SPAN, 31'(v_ys));

      // The sender idles lightly while the receiver stalls often, then the roles swap, and
      // the last phases run with neither side idling but for one receiver hold in phase 4.
      if (ph < 2) begin
        send_idle_pct = 11;
        recv_idle_pct = 63;
      end else if (ph < 4) begin
        send_idle_pct = 63;
        recv_idle_pct = 11;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 4 && n == 30) begin
          hold_req = 1'b1;
        end
        if ($urandom_range(0, 3) == 0) begin
          col = 10'(384 + $urandom_range(0, 255));
          row = 10'(384 + $urandom_range(0, 255));
        end else begin
          col = 10'($urandom_range(0, 1023));
          row = 10'($urandom_range(0, 1023));
        end
        send_pixel(col, row, 1'b0, '0);
      end
      s_tvalid <= 1'b0;
    end

    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (jetp_pkg::MAG_W + 5 + 16) @(posedge clk);
    if (mismatches == 0) begin
      $display("** julia_escape_time_pixel_top: PASSED **");
    end else begin
      $display("** julia_escape_time_pixel_top: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

[julia_escape_time_pixel_top.f]
hdl/jetp_pkg.sv
hdl/jetp_div.sv
hdl/julia_escape_time_pixel_top.sv
hdl/jetp_checker.sv
verif/julia_escape_time_pixel_top_tb.sv
